[sv/rgb565_cell_average_quantizer_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the cell average quantizer modules
// ----------------------------------------------------------------------------
`ifndef RGB565_CELL_AVERAGE_QUANTIZER_TOP_MACROS_SVH
`define RGB565_CELL_AVERAGE_QUANTIZER_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define CAVQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define CAVQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/cavq_pkg.sv]
// ----------------------------------------------------------------------------
// cavq_pkg
// Shared constants, codes and helpers of the cell average quantizer.
// ----------------------------------------------------------------------------
package cavq_pkg;

   // default configuration
   localparam int MAX_CELL_PIXELS_DEFAULT = 4096;
   localparam int QUEUE_DEPTH_DEFAULT     = 4;

   // level count of one 8-bit plane
   localparam int BYTE_LEVELS = 256;

   // input opcodes
   localparam logic OP_PIXEL       = 1'b0;
   localparam logic OP_TABLE_WRITE = 1'b1;

   // plane codes
   localparam logic [1:0] PLANE_RED   = 2'd0;
   localparam logic [1:0] PLANE_GREEN = 2'd1;
   localparam logic [1:0] PLANE_BLUE  = 2'd2;
   localparam logic [1:0] PLANE_SAT   = 2'd3;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // 5-bit channel to 8 bits by bit replication
   function automatic logic [7:0] expand5(input logic [4:0] x);
      return {x, x[4:2]};
   endfunction

   // 6-bit channel to 8 bits by bit replication
   function automatic logic [7:0] expand6(input logic [5:0] x);
      return {x, x[5:4]};
   endfunction

endpackage

[sv/cavq_queue.sv]
// ----------------------------------------------------------------------------
// cavq_queue
// Small FIFO of work entries between the accumulating front and the back end.
// ----------------------------------------------------------------------------
`include "rgb565_cell_average_quantizer_top_macros.svh"

module cavq_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = cavq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [WIDTH-1:0]      push_data,
   input  logic                  pop,
   output logic [WIDTH-1:0]      pop_data,
   output cavq_pkg::q_status_type status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  fill_ff, fill_in;

   // status and head of queue
   assign status.full  = (fill_ff == CNTW'(DEPTH));
   assign status.empty = (fill_ff == '0);
   assign pop_data     = slot_ff[rd_ptr_ff];

   // pointer and fill updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `CAVQ_ASSERT(a_no_push_full, !(push && status.full), "queue pushed while full")
   `CAVQ_ASSERT(a_no_pop_empty, !(pop && status.empty), "queue popped while empty")
   `CAVQ_ASSERT(a_fill_bound, fill_ff <= CNTW'(DEPTH), "queue fill beyond depth")

endmodule

[sv/cavq_front.sv]
// ----------------------------------------------------------------------------
// cavq_front
// Accepts items, accumulates channel sums per cell and queues work entries.
// ----------------------------------------------------------------------------
module cavq_front #(
   parameter int MAX_CELL_PIXELS = cavq_pkg::MAX_CELL_PIXELS_DEFAULT,
   parameter int EW = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_opcode,
   input  logic [15:0]            req_pixel_word,
   input  logic                   req_last_in_cell,
   input  logic [7:0]             req_table_index,
   input  logic signed [7:0]      req_table_value,
   input  cavq_pkg::q_status_type q_status,
   output logic                   push,
   output logic [EW-1:0]          push_data
);

   localparam int CW = $clog2(MAX_CELL_PIXELS + 1);
   localparam int SW = $clog2(MAX_CELL_PIXELS * (cavq_pkg::BYTE_LEVELS - 1) + 1);

   logic [SW-1:0] red_sum_ff, red_sum_in;
   logic [SW-1:0] green_sum_ff, green_sum_in;
   logic [SW-1:0] blue_sum_ff, blue_sum_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] red_acc, green_acc, blue_acc;
   logic [CW-1:0] count_acc;
   logic [7:0]    red8, green8, blue8;
   logic          room;
   logic          accept;

   // only a full queue holds off the producer
   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   // channel expansion and saturating accumulation
   assign red8   = cavq_pkg::expand5(req_pixel_word[15:11]);
   assign green8 = cavq_pkg::expand6(req_pixel_word[10:5]);
   assign blue8  = cavq_pkg::expand5(req_pixel_word[4:0]);
   assign room   = (count_ff < CW'(MAX_CELL_PIXELS));

   always_comb begin
      red_acc   = red_sum_ff;
      green_acc = green_sum_ff;
      blue_acc  = blue_sum_ff;
      count_acc = count_ff;
      if (room) begin
         red_acc   = red_sum_ff + SW'(red8);
         green_acc = green_sum_ff + SW'(green8);
         blue_acc  = blue_sum_ff + SW'(blue8);
         count_acc = count_ff + 1'b1;
      end
   end

   // accumulator next state; a closing pixel clears the cell
   always_comb begin
      red_sum_in   = red_sum_ff;
      green_sum_in = green_sum_ff;
      blue_sum_in  = blue_sum_ff;
      count_in     = count_ff;
      if (accept && req_opcode == cavq_pkg::OP_PIXEL) begin
         if (req_last_in_cell) begin
            red_sum_in   = '0;
            green_sum_in = '0;
            blue_sum_in  = '0;
            count_in     = '0;
         end else begin
            red_sum_in   = red_acc;
            green_sum_in = green_acc;
            blue_sum_in  = blue_acc;
            count_in     = count_acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_sum_ff   <= '0;
         green_sum_ff <= '0;
         blue_sum_ff  <= '0;
         count_ff     <= '0;
      end else begin
         red_sum_ff   <= red_sum_in;
         green_sum_ff <= green_sum_in;
         blue_sum_ff  <= blue_sum_in;
         count_ff     <= count_in;
      end
   end

   // table writes and closed cells go to the back end in order
   assign push = accept && (req_opcode == cavq_pkg::OP_TABLE_WRITE || req_last_in_cell);
   assign push_data = {req_opcode, req_table_index, req_table_value,
                       red_acc, green_acc, blue_acc, count_acc};

endmodule

[sv/cavq_back.sv]
// ----------------------------------------------------------------------------
// cavq_back
// Executes queued entries: table writes, rounded means and saturation through
// a shared radix-2 divider, then table lookup and plane emission.
// ----------------------------------------------------------------------------
`include "rgb565_cell_average_quantizer_top_macros.svh"

module cavq_back #(
   parameter int MAX_CELL_PIXELS = cavq_pkg::MAX_CELL_PIXELS_DEFAULT,
   parameter int EW = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cavq_pkg::q_status_type q_status,
   input  logic [EW-1:0]          pop_data,
   output logic                   pop,
   input  logic                   sat_enable,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [7:0]      rsp_quantized_value,
   output logic [1:0]             rsp_plane_index,
   output logic                   rsp_last_of_cell
);

   localparam int CW   = $clog2(MAX_CELL_PIXELS + 1);
   localparam int SW   = $clog2(MAX_CELL_PIXELS * (cavq_pkg::BYTE_LEVELS - 1) + 1);
   localparam int DW   = (CW + 8 > 16) ? CW + 8 : 16;
   localparam int DVW  = (CW > 8) ? CW : 8;
   localparam int ITW  = $clog2(DW);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_DIV,
      S_SAT_PREP,
      S_LOOKUP,
      S_EMIT
   } state_type;

   state_type       state_ff;
   logic [SW-1:0]   red_sum_ff, green_sum_ff, blue_sum_ff;
   logic [CW-1:0]   count_ff;
   logic            sat_en_ff;
   logic [1:0]      plane_ff;
   logic [7:0]      mean_ff [4];
   logic [DW-1:0]   dvd_ff;
   logic [DVW-1:0]  rem_ff;
   logic [DVW-1:0]  divisor_ff;
   logic [ITW-1:0]  iter_ff;
   logic            rsp_valid_ff;
   logic [7:0]      rsp_value_ff;
   logic [1:0]      rsp_plane_ff;
   logic            rsp_last_ff;

   logic [7:0]      qtable_mem [cavq_pkg::BYTE_LEVELS];
   logic [7:0]      rd_data_ff;

   // queue entry fields
   logic            e_opcode;
   logic [7:0]      e_index;
   logic [7:0]      e_value;
   logic [SW-1:0]   e_red, e_green, e_blue;
   logic [CW-1:0]   e_count;

   assign {e_opcode, e_index, e_value, e_red, e_green, e_blue, e_count} = pop_data;

   // take one entry whenever idle
   assign pop = (state_ff == S_IDLE) && !q_status.empty;

   // divider step: shift one dividend bit into the partial remainder
   logic [DVW:0]    trial;
   logic [DVW:0]    diff;
   logic            q_bit;
   logic [DVW-1:0]  rem_next;
   logic [DW-1:0]   quotient;

   assign trial    = {rem_ff, dvd_ff[DW-1]};
   assign diff     = trial - {1'b0, divisor_ff};
   assign q_bit    = (trial >= {1'b0, divisor_ff});
   assign rem_next = q_bit ? diff[DVW-1:0] : trial[DVW-1:0];
   assign quotient = {dvd_ff[DW-2:0], q_bit};

   // rounded-mean dividend of the current plane
   logic [SW-1:0]   sum_sel;
   logic [DW-1:0]   mean_dvd;

   always_comb begin
      case (plane_ff)
         cavq_pkg::PLANE_RED:   sum_sel = red_sum_ff;
         cavq_pkg::PLANE_GREEN: sum_sel = green_sum_ff;
         default:               sum_sel = blue_sum_ff;
      endcase
   end

   assign mean_dvd = DW'(sum_sel) + DW'(count_ff >> 1);

   // saturation numerator (max-min)*255 + max/2
   logic [7:0]      hi_rg, lo_rg, sat_hi, sat_lo, sat_diff;
   logic [15:0]     sat_num;

   assign hi_rg    = (mean_ff[0] > mean_ff[1]) ? mean_ff[0] : mean_ff[1];
   assign lo_rg    = (mean_ff[0] < mean_ff[1]) ? mean_ff[0] : mean_ff[1];
   assign sat_hi   = (hi_rg > mean_ff[2]) ? hi_rg : mean_ff[2];
   assign sat_lo   = (lo_rg < mean_ff[2]) ? lo_rg : mean_ff[2];
   assign sat_diff = sat_hi - sat_lo;
   assign sat_num  = {sat_diff, 8'd0} - {8'd0, sat_diff} + {9'd0, sat_hi[7:1]};

   // output register is free when empty or being taken
   logic out_free;
   logic last_plane;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_plane = (plane_ff == cavq_pkg::PLANE_SAT) ||
                       (plane_ff == cavq_pkg::PLANE_BLUE && !sat_en_ff);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         plane_ff     <= cavq_pkg::PLANE_RED;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in S_EMIT a taken item is always replaced by the next plane
         if (rsp_valid_ff && !rsp_stall && state_ff != S_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (pop && e_opcode == cavq_pkg::OP_PIXEL) begin
                  red_sum_ff   <= e_red;
                  green_sum_ff <= e_green;
                  blue_sum_ff  <= e_blue;
                  count_ff     <= e_count;
                  sat_en_ff    <= sat_enable;
                  plane_ff     <= cavq_pkg::PLANE_RED;
                  state_ff     <= S_LOAD;
               end
            end
            S_LOAD: begin
               dvd_ff     <= mean_dvd;
               divisor_ff <= DVW'(count_ff);
               rem_ff     <= '0;
               iter_ff    <= ITW'(DW - 1);
               state_ff   <= S_DIV;
            end
            S_DIV: begin
               dvd_ff <= quotient;
               rem_ff <= rem_next;
               if (iter_ff != '0) begin
                  iter_ff <= iter_ff - 1'b1;
               end else begin
                  mean_ff[plane_ff] <= quotient[7:0];
                  if (plane_ff == cavq_pkg::PLANE_SAT) begin
                     plane_ff <= cavq_pkg::PLANE_RED;
                     state_ff <= S_LOOKUP;
                  end else if (plane_ff == cavq_pkg::PLANE_BLUE) begin
                     if (sat_en_ff) begin
                        state_ff <= S_SAT_PREP;
                     end else begin
                        plane_ff <= cavq_pkg::PLANE_RED;
                        state_ff <= S_LOOKUP;
                     end
                  end else begin
                     plane_ff <= plane_ff + 1'b1;
                     state_ff <= S_LOAD;
                  end
               end
            end
            S_SAT_PREP: begin
               if (sat_hi == 8'd0) begin
                  mean_ff[3] <= 8'd0;
                  plane_ff   <= cavq_pkg::PLANE_RED;
                  state_ff   <= S_LOOKUP;
               end else begin
                  dvd_ff     <= DW'(sat_num);
                  divisor_ff <= DVW'(sat_hi);
                  rem_ff     <= '0;
                  iter_ff    <= ITW'(DW - 1);
                  plane_ff   <= cavq_pkg::PLANE_SAT;
                  state_ff   <= S_DIV;
               end
            end
            S_LOOKUP: begin
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= rd_data_ff;
                  rsp_plane_ff <= plane_ff;
                  rsp_last_ff  <= last_plane;
                  if (last_plane) begin
                     plane_ff <= cavq_pkg::PLANE_RED;
                     state_ff <= S_IDLE;
                  end else begin
                     plane_ff <= plane_ff + 1'b1;
                     state_ff <= S_LOOKUP;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // quantization table: written from queued entries, read once per plane
   always_ff @(posedge clock) begin
      if (pop && e_opcode == cavq_pkg::OP_TABLE_WRITE) begin
         qtable_mem[e_index] <= e_value;
      end
      if (state_ff == S_LOOKUP) begin
         rd_data_ff <= qtable_mem[mean_ff[plane_ff]];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_quantized_value = signed'(rsp_value_ff);
   assign rsp_plane_index     = rsp_plane_ff;
   assign rsp_last_of_cell    = rsp_last_ff;

   // a non-final plane taken means another plane is loaded or on its way
   logic mid_cell_take;
   logic plane_follows;

   assign mid_cell_take = rsp_valid_ff && !rsp_stall && !rsp_last_ff;
   assign plane_follows = rsp_valid_ff || (state_ff != S_IDLE);

   `CAVQ_ASSERT(a_div_nonzero, state_ff != S_DIV || divisor_ff != '0, "divide by zero")
   `CAVQ_ASSERT_NEXT(a_emit_order, mid_cell_take, plane_follows, "cell cut short")
   `CAVQ_ASSERT(a_sat_plane, !rsp_valid_ff || rsp_plane_ff != cavq_pkg::PLANE_SAT ||
      sat_en_ff, "saturation plane emitted while disabled")

endmodule

[sv/rgb565_cell_average_quantizer_top.sv]
// ----------------------------------------------------------------------------
// rgb565_cell_average_quantizer_top
// RGB565 cell averaging with table quantization of each plane mean.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries pixels (opcode 0) and table writes (opcode 1). An item is
//          taken when req_valid is high and req_stall low. Non-closing pixels
//          enter the front accumulators at one item per cycle unless stalled.
//   rsp_*  gives one item per plane (red, green, blue, optional saturation),
//          taken when rsp_valid is high and rsp_stall low; the last plane of a
//          cell has rsp_last_of_cell set.
//   csr_*  writes the saturation plane enable; always ready.
// Flow: a closed cell or table write enters a small queue.
//   The back end divides with one quotient bit per cycle over D = 21 bits at
//   the default cell size (D = max(clog2(MAX_CELL_PIXELS+1)+8, 16)): each
//   mean is loaded and divided in turn, then saturation if enabled, and each
//   plane then gets a table lookup and emission. A table write is done as
//   its entry is popped; other entries wait until the back end is idle.
// Reset clears the accumulators, queue, sequencer and output register; table
//   contents are undefined until written. A stalled receiver holds the output
//   item, then the back end, then the queue; req_stall rises when it is full.
// ----------------------------------------------------------------------------
module rgb565_cell_average_quantizer_top #(
   parameter int MAX_CELL_PIXELS = cavq_pkg::MAX_CELL_PIXELS_DEFAULT,
   parameter int QUEUE_DEPTH     = cavq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_opcode,
   input  logic [15:0]       req_pixel_word,
   input  logic              req_last_in_cell,
   input  logic [7:0]        req_table_index,
   input  logic signed [7:0] req_table_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [7:0] rsp_quantized_value,
   output logic [1:0]        rsp_plane_index,
   output logic              rsp_last_of_cell,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);

   localparam int CW = $clog2(MAX_CELL_PIXELS + 1);
   localparam int SW = $clog2(MAX_CELL_PIXELS * (cavq_pkg::BYTE_LEVELS - 1) + 1);
   localparam int EW = 1 + 8 + 8 + 3 * SW + CW;

   cavq_pkg::q_status_type q_status;
   logic                   push;
   logic [EW-1:0]          push_data;
   logic                   pop;
   logic [EW-1:0]          pop_data;
   logic                   sat_enable_ff;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_enable_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         sat_enable_ff <= csr_data;
      end
   end

   cavq_front #(
      .MAX_CELL_PIXELS (MAX_CELL_PIXELS),
      .EW              (EW)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_pixel_word   (req_pixel_word),
      .req_last_in_cell (req_last_in_cell),
      .req_table_index  (req_table_index),
      .req_table_value  (req_table_value),
      .q_status         (q_status),
      .push             (push),
      .push_data        (push_data)
   );

   cavq_queue #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   cavq_back #(
      .MAX_CELL_PIXELS (MAX_CELL_PIXELS),
      .EW              (EW)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_status            (q_status),
      .pop_data            (pop_data),
      .pop                 (pop),
      .sat_enable          (sat_enable_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_quantized_value (rsp_quantized_value),
      .rsp_plane_index     (rsp_plane_index),
      .rsp_last_of_cell    (rsp_last_of_cell)
   );

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RGB565 cell average quantizer. A local
// predictor keeps its own accumulators, table copy and plane enable, and
// every output item is compared against the oldest pending plane. A short
// table of directed items comes first: extremes, table writes, partial
// cells and cell overflow. Random cells follow under several idle and stall
// mixes, including one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;

   localparam int MAX_CELL     = cavq_pkg::MAX_CELL_PIXELS_DEFAULT;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES  = 500;
   localparam int PHASE_ITEMS  = 45;

   // one output plane byte
   typedef struct packed {
      logic signed [7:0] q;
      logic [1:0]        plane;
      logic              last;
   } plane_item_type;

   typedef enum logic { ROW_ITEM, ROW_CSR } row_kind_type;

   // directed row: n_typed < 0 means the predictor supplies the planes
   typedef struct {
      row_kind_type kind;
      logic         op;
      logic [15:0]  word;
      logic         last;
      int           reps;
      logic [7:0]   idx;
      logic [7:0]   val;
      int           n_typed;
      logic [31:0]  q_typed;
   } dir_row_type;

   logic              clock;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic              req_opcode       = cavq_pkg::OP_PIXEL;
   logic [15:0]       req_pixel_word   = '0;
   logic              req_last_in_cell = 1'b0;
   logic [7:0]        req_table_index  = '0;
   logic signed [7:0] req_table_value  = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic signed [7:0] rsp_quantized_value;
   logic [1:0]        rsp_plane_index;
   logic              rsp_last_of_cell;
   logic              csr_valid        = 1'b0;
   logic              csr_ready;
   logic              csr_data         = 1'b0;

   // predictor state
   logic [19:0]       acc_sum [3];
   logic [12:0]       acc_count;
   logic signed [7:0] shadow_table [256];
   logic              sat_enable;
   plane_item_type    cell_result [4];

   plane_item_type    pending_planes [$];
   dir_row_type       dir_rows [$];
   int                fail_count    = 0;
   int                send_idle_pct = 0;
   int                stall_pct     = 0;
   int                hold_asked    = 0;
   int                hold_served   = 0;
   int                hold_left     = 0;

   rgb565_cell_average_quantizer_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_pixel_word      (req_pixel_word),
      .req_last_in_cell    (req_last_in_cell),
      .req_table_index     (req_table_index),
      .req_table_value     (req_table_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_quantized_value (rsp_quantized_value),
      .rsp_plane_index     (rsp_plane_index),
      .rsp_last_of_cell    (rsp_last_of_cell),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // run limit
   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: FAIL");
      $finish;
   end

   // receiver stall: random, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // output checker
   always @(posedge clock) begin
      plane_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_planes.size() == 0) begin
            report_mismatch("item with nothing pending", rsp_quantized_value, 0);
         end else begin
            want = pending_planes.pop_front();
            if (rsp_quantized_value !== want.q)
               report_mismatch("quantized_value", rsp_quantized_value, $signed(want.q));
            if (rsp_plane_index !== want.plane)
               report_mismatch("plane_index", rsp_plane_index, want.plane);
            if (rsp_last_of_cell !== want.last)
               report_mismatch("last_of_cell", rsp_last_of_cell, want.last);
         end
      end
   end

   // cell accumulation and plane prediction; returns the number of planes
   function automatic int predict_cell(input logic op, input logic [15:0] word,
                                       input logic last, input logic [7:0] idx,
                                       input logic [7:0] val);
      int chan [3];
      int mean [3];
      int hi, lo, sat, planes;
      if (op == cavq_pkg::OP_TABLE_WRITE) begin
         shadow_table[idx] = val;
         return 0;
      end
      if (acc_count < MAX_CELL) begin
         chan[0] = word[15:11];
         chan[1] = word[10:5];
         chan[2] = word[4:0];
         acc_sum[0] = acc_sum[0] + 20'((chan[0] << 3) | (chan[0] >> 2));
         acc_sum[1] = acc_sum[1] + 20'((chan[1] << 2) | (chan[1] >> 4));
         acc_sum[2] = acc_sum[2] + 20'((chan[2] << 3) | (chan[2] >> 2));
         acc_count  = acc_count + 13'd1;
      end
      if (!last) return 0;
      planes = sat_enable ? 4 : 3;
      for (int k = 0; k < 3; k++) begin
         mean[k] = (int'(acc_sum[k]) + int'(acc_count) / 2) / int'(acc_count);
         cell_result[k].q     = shadow_table[mean[k]];
         cell_result[k].plane = 2'(k);
         cell_result[k].last  = (k + 1 == planes);
      end
      if (planes == 4) begin
         hi = (mean[0] > mean[1]) ? mean[0] : mean[1];
         lo = (mean[0] < mean[1]) ? mean[0] : mean[1];
         hi = (hi > mean[2]) ? hi : mean[2];
         lo = (lo < mean[2]) ? lo : mean[2];
         sat = (hi > 0) ? ((hi - lo) * (cavq_pkg::BYTE_LEVELS - 1) + hi / 2) / hi : 0;
         cell_result[3].q     = shadow_table[sat];
         cell_result[3].plane = cavq_pkg::PLANE_SAT;
         cell_result[3].last  = 1'b1;
      end
      for (int k = 0; k < 3; k++) acc_sum[k] = '0;
      acc_count = '0;
      return planes;
   endfunction

   // offer one item, wait for acceptance, then queue its planes
   task automatic issue_item(input logic op, input logic [15:0] word, input logic last,
                             input logic [7:0] idx, input logic [7:0] val,
                             input int n_typed, input logic [31:0] q_typed);
      int n;
      plane_item_type typed_item;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_pixel_word   <= word;
      req_last_in_cell <= last;
      req_table_index  <= idx;
      req_table_value  <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n = predict_cell(op, word, last, idx, val);
      if (n_typed < 0) begin
         for (int k = 0; k < n; k++) pending_planes.push_back(cell_result[k]);
      end else begin
         for (int k = 0; k < n_typed; k++) begin
            typed_item.q     = q_typed[31 - 8 * k -: 8];
            typed_item.plane = 2'(k);
            typed_item.last  = (k == n_typed - 1);
            pending_planes.push_back(typed_item);
         end
      end
   endtask

   // plane enable write, only once the block has drained
   task automatic set_sat_plane(input logic v);
      req_valid <= 1'b0;
      while (pending_planes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      sat_enable = v;
   endtask

   function automatic void add_row(row_kind_type kind, logic op, logic [15:0] word,
                                   logic last, int reps, logic [7:0] idx,
                                   logic [7:0] val, int n_typed, logic [31:0] q_typed);
      dir_row_type row;
      row.kind    = kind;
      row.op      = op;
      row.word    = word;
      row.last    = last;
      row.reps    = reps;
      row.idx     = idx;
      row.val     = val;
      row.n_typed = n_typed;
      row.q_typed = q_typed;
      dir_rows.push_back(row);
   endfunction

   // random cells, with stray table writes now and then, even inside a cell
   task automatic run_phase(input int idle_pct, input int stall, input logic sat,
                            input bit pressure);
      int issued, cell_left, pick;
      logic [15:0] word;
      set_sat_plane(sat);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      if (pressure) hold_asked++;
      issued    = 0;
      cell_left = 0;
      while (issued < PHASE_ITEMS || cell_left > 0) begin
         if (cell_left == 0)
            cell_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 5)
                                                     : $urandom_range(8, 40);
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            issue_item(cavq_pkg::OP_TABLE_WRITE, 16'($urandom), 1'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), -1, '0);
         end else begin
            if (pick < 16) word = 16'h0000;
            else if (pick < 24) word = 16'hFFFF;
            else word = 16'($urandom);
            cell_left--;
            issue_item(cavq_pkg::OP_PIXEL, word, cell_left == 0, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), -1, '0);
         end
         issued++;
      end
   endtask

   // stimulus
   initial begin
      dir_row_type row;
      for (int k = 0; k < 3; k++) acc_sum[k] = '0;
      acc_count  = '0;
      sat_enable = 1'b0;

      @(posedge clock);
      while (reset) @(posedge clock);

      // every entry gets level minus 128, so the typed rows read off easily
      for (int i = 0; i < 256; i++)
         issue_item(cavq_pkg::OP_TABLE_WRITE, 16'($urandom), 1'($urandom_range(0, 1)),
                    8'(i), 8'(i) ^ 8'h80, -1, '0);

      //      kind      op                        word      last reps idx    val    n   planes
      add_row(ROW_CSR,  cavq_pkg::OP_PIXEL,       16'h0000, 1'b0, 1,    8'h00, 8'h00, 0,
              32'h0);
      add_row(ROW_ITEM, cavq_pkg::OP_PIXEL,       16'h0000, 1'b1, 1,    8'h00, 8'h00, 3,
              32'h80808000);
      add_row(ROW_ITEM, cavq_pkg::OP_PIXEL,       16'hFFFF, 1'b1, 1,    8'hFF, 8'hFF, 3,
              32'h7F7F7F00);
      add_row(ROW_ITEM, cavq_pkg::OP_PIXEL,       16'hF800, 1'b1, 1,    8'h00, 8'h00, 3,
              32'h7F808000);
      add_row(ROW_ITEM, cavq_pkg::OP_PIXEL,       16'h07E0, 1'b1, 1,    8'h00, 8'h00, 3,
              32'h807F8000);
      add_row(ROW_ITEM, cavq_pkg::OP_PIXEL,       16'h001F, 1'b1, 1,    8'h00, 8'h00, 3,
              32'h80807F00);
      // two-pixel cell rounds half up to level 128
      add_row(ROW_ITEM, cavq_pkg::OP_PIXEL,       16'hFFFF, 1'b0, 1,    8'h00, 8'h00, -1,
              32'h0);
      add_row(ROW_ITEM, cavq_pkg::OP_PIXEL,       16'h0000, 1'b1, 1,    8'h00, 8'h00, 3,
              32'h00000000);
      // table write ignores the pixel and last fields
      add_row(ROW_ITEM, cavq_pkg::OP_TABLE_WRITE, 16'hFFFF, 1'b1, 1,    8'h05, 8'h55, 0,
              32'h0);
      add_row(ROW_ITEM, cavq_pkg::OP_PIXEL,       16'h1234, 1'b0, 1,    8'hFF, 8'h7F, -1,
              32'h0);
      add_row(ROW_ITEM, cavq_pkg::OP_PIXEL,       16'h5678, 1'b1, 1,    8'h00, 8'h80, -1,
              32'h0);
      // overflow: pixels past the cell limit, the closing one too, are dropped
      add_row(ROW_ITEM, cavq_pkg::OP_PIXEL,       16'h0000, 1'b0, MAX_CELL, 8'h00, 8'h00, -1,
              32'h0);
      add_row(ROW_ITEM, cavq_pkg::OP_PIXEL,       16'hFFFF, 1'b1, 10,   8'h00, 8'h00, 3,
              32'h80808000);
      // saturation plane on
      add_row(ROW_CSR,  cavq_pkg::OP_PIXEL,       16'h0000, 1'b0, 1,    8'h00, 8'h01, 0,
              32'h0);
      add_row(ROW_ITEM, cavq_pkg::OP_PIXEL,       16'h0000, 1'b1, 1,    8'h00, 8'h00, 4,
              32'h80808080);
      add_row(ROW_ITEM, cavq_pkg::OP_PIXEL,       16'hFFFF, 1'b1, 1,    8'h00, 8'h00, 4,
              32'h7F7F7F80);
      add_row(ROW_ITEM, cavq_pkg::OP_PIXEL,       16'hF800, 1'b1, 1,    8'h00, 8'h00, 4,
              32'h7F80807F);
      add_row(ROW_ITEM, cavq_pkg::OP_PIXEL,       16'h8410, 1'b1, 1,    8'h00, 8'h00, -1,
              32'h0);
      add_row(ROW_ITEM, cavq_pkg::OP_PIXEL,       16'h0821, 1'b1, 1,    8'h00, 8'h00, -1,
              32'h0);
      // table write in the middle of a cell leaves the sums alone
      add_row(ROW_ITEM, cavq_pkg::OP_PIXEL,       16'hFFFF, 1'b0, 1,    8'h00, 8'h00, -1,
              32'h0);
      add_row(ROW_ITEM, cavq_pkg::OP_TABLE_WRITE, 16'h0000, 1'b0, 1,    8'hC8, 8'h07, -1,
              32'h0);
      add_row(ROW_ITEM, cavq_pkg::OP_PIXEL,       16'h0000, 1'b1, 1,    8'h00, 8'h00, -1,
              32'h0);

      foreach (dir_rows[r]) begin
         row = dir_rows[r];
         if (row.kind == ROW_CSR) begin
            set_sat_plane(row.val[0]);
         end else begin
            for (int i = 0; i < row.reps; i++)
               issue_item(row.op, row.word, (i == row.reps - 1) ? row.last : 1'b0,
                          row.idx, row.val, (i == row.reps - 1) ? row.n_typed : -1,
                          row.q_typed);
         end
      end

      // random part: full rate with a long hold-off, then the idle and stall mixes
      run_phase(0, 0, 1'b1, 1'b1);
      run_phase(65, 0, 1'b0, 1'b0);
      run_phase(0, 65, 1'b1, 1'b0);
      run_phase(28, 28, 1'b0, 1'b0);

      req_valid <= 1'b0;
      while (pending_planes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
